// ===== hw/rtl/usrf_pkg.sv =====
// Package for the USART register file: item types, request and register codes,
// bit positions and the character-size mask lookup. No dependencies.
package usrf_pkg;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] rx_byte;
        logic       power_down;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_dropped;
        logic       rx_ready;
        logic       rx_irq;
        logic       tx_irq;
        logic       empty_irq;
    } t_rsp;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_RX    = 2'd2;
    localparam logic [1:0] REQ_POWER = 2'd3;

    localparam logic [2:0] ADDR_STATUS_A = 3'd0;
    localparam logic [2:0] ADDR_CTRL_B   = 3'd1;
    localparam logic [2:0] ADDR_CTRL_C   = 3'd2;
    localparam logic [2:0] ADDR_BAUD_LO  = 3'd4;
    localparam logic [2:0] ADDR_BAUD_HI  = 3'd5;
    localparam logic [2:0] ADDR_DATA     = 3'd6;

    localparam logic [7:0] A_WRITABLE = 8'b0100_0011;
    localparam logic [7:0] B_WRITABLE = 8'b1111_1101;
    localparam logic [7:0] A_RESET    = 8'b0010_0000;
    localparam logic [7:0] C_RESET    = 8'b0000_0110;
    localparam logic [7:0] BAUD_HI_MASK = 8'b0000_1111;
    localparam logic [7:0] MASK_FULL  = 8'b1111_1111;

    localparam int A_RXC = 7;
    localparam int A_TXC = 6;
    localparam int A_DRE = 5;
    localparam int B_RXCIE = 6 + 1;
    localparam int B_TXCIE = 6;
    localparam int B_DREIE = 5;
    localparam int B_RXEN  = 4;
    localparam int B_TXEN  = 3;
    localparam int B_CSZ2  = 2;
    localparam int C_CSZ1  = 2;
    localparam int C_CSZ0  = 1;

    function automatic logic [7:0] f_size_mask(input logic [2:0] code, input logic [7:0] old);
        logic [7:0] m;
        m = old;
        case (code)
            3'd0: m = 8'b0001_1111;
            3'd1: m = 8'b0011_1111;
            3'd2: m = 8'b0111_1111;
            3'd3, 3'd7: m = MASK_FULL;
            default: m = old;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/usrf_regs.sv =====
// USART register state and the per-item update logic.
// Depends on usrf_pkg.
module usrf_regs
    import usrf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_req i_req,
    output t_rsp o_rsp
);

    logic [7:0] r_status_a, n_status_a;
    logic [7:0] r_ctrl_b, n_ctrl_b;
    logic [7:0] r_ctrl_c, n_ctrl_c;
    logic [7:0] r_baud_lo, n_baud_lo;
    logic [3:0] r_baud_hi, n_baud_hi;
    logic [7:0] r_holder, n_holder;
    logic       r_full, n_full;
    logic [7:0] r_mask, n_mask;
    logic       r_en, n_en;
    logic       r_irq_rx, n_irq_rx;
    logic       r_irq_tx, n_irq_tx;
    logic       r_irq_dre, n_irq_dre;
    logic [7:0] rdata;
    logic       txv;
    logic [7:0] txb;
    logic       dropped;

    always_comb begin
        n_status_a = r_status_a;
        n_ctrl_b   = r_ctrl_b;
        n_ctrl_c   = r_ctrl_c;
        n_baud_lo  = r_baud_lo;
        n_baud_hi  = r_baud_hi;
        n_holder   = r_holder;
        n_full     = r_full;
        n_mask     = r_mask;
        n_en       = r_en;
        n_irq_rx   = r_irq_rx;
        n_irq_tx   = r_irq_tx;
        n_irq_dre  = r_irq_dre;
        rdata      = 8'd0;
        txv        = 1'b0;
        txb        = 8'd0;
        dropped    = 1'b0;
        if (i_vld) begin
            unique case (i_req.req_type)
                REQ_READ: begin
                    if (r_en) begin
                        case (i_req.reg_addr)
                            ADDR_STATUS_A: rdata = r_status_a;
                            ADDR_CTRL_B:   rdata = r_ctrl_b;
                            ADDR_CTRL_C:   rdata = r_ctrl_c;
                            ADDR_BAUD_LO:  rdata = r_baud_lo;
                            ADDR_BAUD_HI:  rdata = {4'd0, r_baud_hi};
                            ADDR_DATA: begin
                                if (r_ctrl_b[B_RXEN]) begin
                                    if (r_full) begin
                                        rdata = r_holder & r_mask;
                                    end
                                    n_full = 1'b0;
                                    n_status_a[A_RXC] = 1'b0;
                                    n_irq_rx = 1'b0;
                                end
                            end
                            default: rdata = 8'd0;
                        endcase
                    end
                end
                REQ_WRITE: begin
                    if (r_en) begin
                        case (i_req.reg_addr)
                            ADDR_STATUS_A: begin
                                n_status_a = (i_req.write_data & A_WRITABLE)
                                           | (r_status_a & ~A_WRITABLE);
                                n_status_a[A_TXC] = 1'b0;
                                if (i_req.write_data[A_TXC]) begin
                                    n_irq_tx = 1'b0;
                                end
                            end
                            ADDR_CTRL_B: begin
                                n_ctrl_b = (i_req.write_data & B_WRITABLE)
                                         | (r_ctrl_b & ~B_WRITABLE);
                                if (!n_ctrl_b[B_RXEN]) begin
                                    n_full = 1'b0;
                                end
                                n_irq_rx  = n_ctrl_b[B_RXCIE] & r_status_a[A_RXC];
                                n_irq_tx  = n_ctrl_b[B_TXCIE] & r_status_a[A_TXC];
                                n_irq_dre = n_ctrl_b[B_DREIE] & r_status_a[A_DRE];
                                n_mask = f_size_mask({n_ctrl_b[B_CSZ2], r_ctrl_c[C_CSZ1],
                                                      r_ctrl_c[C_CSZ0]}, r_mask);
                            end
                            ADDR_CTRL_C: begin
                                n_ctrl_c = i_req.write_data;
                                n_mask = f_size_mask({r_ctrl_b[B_CSZ2], n_ctrl_c[C_CSZ1],
                                                      n_ctrl_c[C_CSZ0]}, r_mask);
                            end
                            ADDR_BAUD_LO: n_baud_lo = i_req.write_data;
                            ADDR_BAUD_HI: n_baud_hi = i_req.write_data[3:0];
                            ADDR_DATA: begin
                                if (r_ctrl_b[B_TXEN]) begin
                                    n_status_a[A_TXC] = ~r_ctrl_b[B_TXCIE];
                                    n_status_a[A_DRE] = 1'b1;
                                    if (r_ctrl_b[B_TXCIE]) begin
                                        n_irq_tx = 1'b1;
                                    end
                                    if (r_ctrl_b[B_DREIE]) begin
                                        n_irq_dre = 1'b1;
                                    end
                                    txv = 1'b1;
                                    txb = i_req.write_data;
                                end
                            end
                            default: n_baud_lo = r_baud_lo;
                        endcase
                    end
                end
                REQ_RX: begin
                    if (r_full || !r_ctrl_b[B_RXEN]) begin
                        dropped = 1'b1;
                    end else begin
                        n_holder = i_req.rx_byte;
                        n_full = 1'b1;
                        n_status_a[A_RXC] = 1'b1;
                        if (r_ctrl_b[B_RXCIE]) begin
                            n_irq_rx = 1'b1;
                        end
                    end
                end
                REQ_POWER: begin
                    n_en = ~i_req.power_down;
                    if (i_req.power_down) begin
                        n_full     = 1'b0;
                        n_status_a = A_RESET;
                        n_ctrl_b   = 8'd0;
                        n_ctrl_c   = C_RESET;
                        n_baud_lo  = 8'd0;
                        n_baud_hi  = 4'd0;
                        n_mask     = MASK_FULL;
                        n_irq_rx   = 1'b0;
                        n_irq_tx   = 1'b0;
                        n_irq_dre  = 1'b0;
                    end
                end
                default: n_en = r_en;
            endcase
        end
    end

    always_comb begin
        o_rsp.read_data  = rdata;
        o_rsp.tx_valid   = txv;
        o_rsp.tx_byte    = txb;
        o_rsp.rx_dropped = dropped;
        o_rsp.rx_ready   = ~n_full & n_ctrl_b[B_RXEN];
        o_rsp.rx_irq     = n_irq_rx;
        o_rsp.tx_irq     = n_irq_tx;
        o_rsp.empty_irq  = n_irq_dre;
    end

    always_ff @(posedge i_clk) begin
        r_holder <= n_holder;
        if (!i_rst_n) begin
            r_status_a <= A_RESET;
            r_ctrl_b   <= 8'd0;
            r_ctrl_c   <= C_RESET;
            r_baud_lo  <= 8'd0;
            r_baud_hi  <= 4'd0;
            r_full     <= 1'b0;
            r_mask     <= MASK_FULL;
            r_en       <= 1'b1;
            r_irq_rx   <= 1'b0;
            r_irq_tx   <= 1'b0;
            r_irq_dre  <= 1'b0;
        end else begin
            r_status_a <= n_status_a;
            r_ctrl_b   <= n_ctrl_b;
            r_ctrl_c   <= n_ctrl_c;
            r_baud_lo  <= n_baud_lo;
            r_baud_hi  <= n_baud_hi;
            r_full     <= n_full;
            r_mask     <= n_mask;
            r_en       <= n_en;
            r_irq_rx   <= n_irq_rx;
            r_irq_tx   <= n_irq_tx;
            r_irq_dre  <= n_irq_dre;
        end
    end

endmodule

// ===== hw/rtl/usart_register_file.sv =====
// Top level of the USART register file: input register, register state, result register.
// Depends on usrf_pkg and usrf_regs.
//
//  channel   handshake          payload
//  request   start / busy       i_item   (t_req)
//  result    o_valid strobe     o_result (t_rsp)
//
// One item per cycle while busy is low; the item goes to the input register, and its result
// is captured in the result register, which raises the strobe.
// busy is high only while reset is applied; the state update is a single register stage.
// Synchronous active-low reset restores all but the data holder and payloads to reset values.
// Results are shown for one cycle and cannot be held off.
module usart_register_file
    import usrf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_item,
    output logic o_valid,
    output t_rsp o_result
);

    logic r_in_vld;
    t_req r_in;
    logic r_out_vld;
    t_rsp r_out;
    t_rsp rsp;

    assign busy = ~i_rst_n;

    usrf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_req   (r_in),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        r_in  <= i_item;
        r_out <= rsp;
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start & ~busy;
            r_out_vld <= r_in_vld;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

`ifndef SYNTH
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("result strobe missing two cycles after item");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_in_vld))
        else $error("result strobe without item");
    a_tx_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.tx_valid |-> !o_result.rx_dropped && o_result.read_data == 8'd0)
        else $error("transmit result mixed with other outcome");
    a_drop_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.rx_dropped |-> !o_result.rx_ready && !o_result.tx_valid)
        else $error("dropped byte while receiver ready");
`endif

endmodule
